/* design/sts_pkg.sv */
package sts_pkg;

	// Default width of the position counters.
	localparam int POSITION_BITS_DEF = 16;
	// Width of the position and length fields on the token channel.
	localparam int TOK_POS_W = 16;
	// Depth of the queue between the classifier and the scanner.
	localparam int QUEUE_DEPTH = 2;
	// Depth of the token buffer; kept a power of two so the pointers wrap.
	localparam int OUT_DEPTH = 4;

	localparam logic [4:0] KIND_EOF    = 5'd0;
	localparam logic [4:0] KIND_IDENT  = 5'd1;
	localparam logic [4:0] KIND_NUMBER = 5'd2;
	localparam logic [4:0] KIND_STRING = 5'd3;
	localparam logic [4:0] KIND_SYMBOL = 5'd4;
	localparam logic [4:0] KIND_FUNC   = 5'd5;
	localparam logic [4:0] KIND_PRINT  = 5'd6;
	localparam logic [4:0] KIND_INT    = 5'd7;
	localparam logic [4:0] KIND_LIST   = 5'd8;
	localparam logic [4:0] KIND_ARRAY  = 5'd9;
	localparam logic [4:0] KIND_IF     = 5'd10;
	localparam logic [4:0] KIND_ELIF   = 5'd11;
	localparam logic [4:0] KIND_ELSE   = 5'd12;
	localparam logic [4:0] KIND_FOR    = 5'd13;
	localparam logic [4:0] KIND_WHILE  = 5'd14;
	localparam logic [4:0] KIND_LT     = 5'd15;
	localparam logic [4:0] KIND_GT     = 5'd16;
	localparam logic [4:0] KIND_LTE    = 5'd17;
	localparam logic [4:0] KIND_GTE    = 5'd18;
	localparam logic [4:0] KIND_EQ     = 5'd19;
	localparam logic [4:0] KIND_NEQ    = 5'd20;
	localparam logic [4:0] KIND_INC    = 5'd21;
	localparam logic [4:0] KIND_DEC    = 5'd22;

	// Classified input item.
	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
		logic       is_space;
		logic       is_ident;   // letter or underscore
		logic       is_digit;
		logic       is_quote;
		logic       is_opstart; // = ! < > + -
	} cls_t;

	// One result item.
	typedef struct packed {
		logic [4:0]           kind;
		logic [TOK_POS_W-1:0] start;
		logic [TOK_POS_W-1:0] length;
		logic [7:0]           first;
		logic                 last;
	} tok_t;

	// Keyword match. The prefix keeps the first character in the low byte,
	// so the words are written back to front.
	function automatic logic [4:0] kw_kind(input logic [39:0] prefix, input logic [2:0] len);
		logic [4:0] k;
		k = KIND_IDENT;
		if (len == 3'd4 && prefix == {8'd0, "cnuf"})       k = KIND_FUNC;
		else if (len == 3'd5 && prefix == "tnirp")         k = KIND_PRINT;
		else if (len == 3'd3 && prefix == {16'd0, "tni"})  k = KIND_INT;
		else if (len == 3'd4 && prefix == {8'd0, "tsil"})  k = KIND_LIST;
		else if (len == 3'd5 && prefix == "yarra")         k = KIND_ARRAY;
		else if (len == 3'd2 && prefix == {24'd0, "fi"})   k = KIND_IF;
		else if (len == 3'd4 && prefix == {8'd0, "file"})  k = KIND_ELIF;
		else if (len == 3'd4 && prefix == {8'd0, "esle"})  k = KIND_ELSE;
		else if (len == 3'd3 && prefix == {16'd0, "rof"})  k = KIND_FOR;
		else if (len == 3'd5 && prefix == "elihw")         k = KIND_WHILE;
		return k;
	endfunction

endpackage

/* design/sts_text_if.sv */
interface sts_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_text;

	modport source (output valid, output character, output end_of_text, input ready);
	modport sink (input valid, input character, input end_of_text, output ready);
endinterface

/* design/sts_token_if.sv */
interface sts_token_if import sts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [4:0]           token_kind;
	logic [TOK_POS_W-1:0] token_start;
	logic [TOK_POS_W-1:0] token_length;
	logic [7:0]           first_char;
	logic                 last_of_run;

	modport source (output valid, output token_kind, output token_start, output token_length,
		output first_char, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start, input token_length,
		input first_char, input last_of_run, output ready);
endinterface

/* design/sts_front.sv */
module sts_front import sts_pkg::*; (
	sts_text_if.sink text,
	output logic     push_valid,
	output cls_t     push_item,
	input  logic     push_ready
);

	logic [7:0] c;

	always_comb begin
		c = text.character;
		push_item.ch         = c;
		// NUL acts as end of text
		push_item.is_end     = text.end_of_text | (c == 8'd0);
		push_item.is_space   = (c == " ") | (c >= 8'd9 && c <= 8'd13);
		push_item.is_ident   = (c >= "a" && c <= "z") | (c >= "A" && c <= "Z") | (c == "_");
		push_item.is_digit   = (c >= "0" && c <= "9");
		push_item.is_quote   = (c == "\"");
		push_item.is_opstart = (c == "=") | (c == "!") | (c == "<") | (c == ">")
			| (c == "+") | (c == "-");
	end

	assign push_valid = text.valid;
	assign text.ready = push_ready;

endmodule

/* design/sts_queue.sv */
module sts_queue import sts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cls_t push_item,
	output logic push_ready,
	output logic pop_valid,
	output cls_t pop_item,
	input  logic pop_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cls_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

/* design/sts_back.sv */
module sts_back import sts_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  cls_t          q_item,
	output logic          q_ready,
	sts_token_if.source   tokens
);

	localparam int PB    = POSITION_BITS;
	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_STRING = 3'd3;
	localparam logic [2:0] MODE_OPER   = 3'd4;

	localparam logic [PB-1:0] POS_MAX = '1;

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v == POS_MAX) ? v : v + PB'(1);
	endfunction

	// scanner state
	logic [2:0]    mode_q;
	logic [7:0]    pend_q;
	logic [PB-1:0] lex_start_q;
	logic [PB-1:0] lex_count_q;
	logic [39:0]   prefix_q;
	logic [PB-1:0] pos_q;
	logic [7:0]    lead_q;

	logic [2:0]    mode_d;
	logic [7:0]    pend_d;
	logic [PB-1:0] lex_start_d;
	logic [PB-1:0] lex_count_d;
	logic [39:0]   prefix_d;
	logic [PB-1:0] pos_d;
	logic [7:0]    lead_d;

	// token buffer
	tok_t             buf_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic       pop;
	logic       out_fire;
	logic       brk;
	logic       a_valid;
	logic       b_valid;
	tok_t       a_tok;
	tok_t       b_tok;
	tok_t       flush_tok;
	logic [4:0] combo;
	logic [2:0] len3;
	logic [7:0] c;
	logic [PB-1:0] p;

	// room for two tokens before an item is taken
	assign q_ready  = (cnt_q <= CNT_W'(OUT_DEPTH - 2));
	assign pop      = q_valid & q_ready;
	assign out_fire = tokens.valid & tokens.ready;

	always_comb begin
		c    = q_item.ch;
		p    = pos_q;
		len3 = (lex_count_q < PB'(6)) ? lex_count_q[2:0] : 3'd7;

		// two-character operators
		combo = KIND_EOF;
		if (c == "=") begin
			if (pend_q == "=")      combo = KIND_EQ;
			else if (pend_q == "!") combo = KIND_NEQ;
			else if (pend_q == "<") combo = KIND_LTE;
			else if (pend_q == ">") combo = KIND_GTE;
		end else if (c == pend_q) begin
			if (c == "+")      combo = KIND_INC;
			else if (c == "-") combo = KIND_DEC;
		end

		// token of whatever lexeme is pending
		flush_tok.start  = TOK_POS_W'(lex_start_q);
		flush_tok.length = TOK_POS_W'(lex_count_q);
		flush_tok.first  = lead_q;
		flush_tok.last   = 1'b0;
		unique case (mode_q)
			MODE_IDENT:  flush_tok.kind = kw_kind(prefix_q, len3);
			MODE_NUMBER: flush_tok.kind = KIND_NUMBER;
			MODE_STRING: flush_tok.kind = KIND_STRING;
			default: begin
				flush_tok.kind   = (pend_q == "<") ? KIND_LT :
					(pend_q == ">") ? KIND_GT : KIND_SYMBOL;
				flush_tok.length = TOK_POS_W'(1);
				flush_tok.first  = pend_q;
			end
		endcase

		unique case (mode_q)
			MODE_IDENT:  brk = ~(q_item.is_ident | q_item.is_digit);
			MODE_NUMBER: brk = ~q_item.is_digit;
			MODE_STRING: brk = 1'b0;
			MODE_OPER:   brk = (combo == KIND_EOF);
			default:     brk = 1'b1;
		endcase

		mode_d      = mode_q;
		pend_d      = pend_q;
		lex_start_d = lex_start_q;
		lex_count_d = lex_count_q;
		prefix_d    = prefix_q;
		lead_d      = lead_q;
		pos_d       = sat_inc(p);
		a_valid     = 1'b0;
		b_valid     = 1'b0;
		a_tok       = flush_tok;
		b_tok.kind   = KIND_SYMBOL;
		b_tok.start  = TOK_POS_W'(p);
		b_tok.length = TOK_POS_W'(1);
		b_tok.first  = c;
		b_tok.last   = 1'b1;

		if (q_item.is_end) begin
			a_valid      = (mode_q != MODE_IDLE);
			b_valid      = 1'b1;
			b_tok.kind   = KIND_EOF;
			b_tok.length = '0;
			b_tok.first  = '0;
			mode_d       = MODE_IDLE;
			pend_d       = '0;
			lex_start_d  = '0;
			lex_count_d  = '0;
			prefix_d     = '0;
			lead_d       = '0;
			pos_d        = '0;
		end else if (brk) begin
			a_valid = (mode_q != MODE_IDLE);
			mode_d  = MODE_IDLE;
			if (q_item.is_ident) begin
				mode_d      = MODE_IDENT;
				lex_start_d = p;
				lex_count_d = PB'(1);
				prefix_d    = {32'd0, c};
				lead_d      = c;
			end else if (q_item.is_digit) begin
				mode_d      = MODE_NUMBER;
				lex_start_d = p;
				lex_count_d = PB'(1);
				lead_d      = c;
			end else if (q_item.is_quote) begin
				mode_d      = MODE_STRING;
				lex_start_d = sat_inc(p);
				lex_count_d = '0;
				lead_d      = '0;
			end else if (q_item.is_opstart) begin
				mode_d      = MODE_OPER;
				pend_d      = c;
				lex_start_d = p;
			end else if (!q_item.is_space) begin
				b_valid = 1'b1;
			end
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					for (int i = 0; i < 5; i++) begin
						if (lex_count_q == PB'(i)) prefix_d[8*i +: 8] = c;
					end
					lex_count_d = sat_inc(lex_count_q);
				end
				MODE_NUMBER: lex_count_d = sat_inc(lex_count_q);
				MODE_STRING: begin
					if (q_item.is_quote) begin
						a_valid = 1'b1;
						mode_d  = MODE_IDLE;
					end else begin
						if (lex_count_q == '0) lead_d = c;
						lex_count_d = sat_inc(lex_count_q);
					end
				end
				default: begin
					// completed two-character operator
					a_valid      = 1'b1;
					a_tok.kind   = combo;
					a_tok.length = TOK_POS_W'(2);
					a_tok.first  = pend_q;
					mode_d       = MODE_IDLE;
				end
			endcase
		end
		a_tok.last = ~b_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pend_q      <= '0;
			lex_start_q <= '0;
			lex_count_q <= '0;
			prefix_q    <= '0;
			pos_q       <= '0;
			lead_q      <= '0;
		end else if (pop) begin
			mode_q      <= mode_d;
			pend_q      <= pend_d;
			lex_start_q <= lex_start_d;
			lex_count_q <= lex_count_d;
			prefix_q    <= prefix_d;
			pos_q       <= pos_d;
			lead_q      <= lead_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && a_valid) begin
			buf_q[wr_q] <= a_tok;
		end
		if (pop && b_valid) begin
			buf_q[wr_q + PTR_W'(a_valid)] <= b_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				wr_q <= wr_q + PTR_W'(a_valid) + PTR_W'(b_valid);
			end
			if (out_fire) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(pop & a_valid) + CNT_W'(pop & b_valid) - CNT_W'(out_fire);
		end
	end

	assign tokens.valid        = (cnt_q != '0);
	assign tokens.token_kind   = buf_q[rd_q].kind;
	assign tokens.token_start  = buf_q[rd_q].start;
	assign tokens.token_length = buf_q[rd_q].length;
	assign tokens.first_char   = buf_q[rd_q].first;
	assign tokens.last_of_run  = buf_q[rd_q].last;

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OUT_DEPTH))
		else $error("token buffer overflow");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.is_end) |=> (mode_q == MODE_IDLE && pos_q == '0))
		else $error("end of text did not restart the scanner");

	a_combo_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !q_item.is_end && mode_q == MODE_OPER && combo != KIND_EOF)
		|=> (mode_q == MODE_IDLE))
		else $error("operator pair left scanner busy");

	a_pair_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && !tokens.last_of_run) |-> (cnt_q >= CNT_W'(2)))
		else $error("first token of a pair shown without its partner");

endmodule

/* design/script_token_scanner_top.sv */
// A character accepted from the text port is classified and queued, then
// scanned into the token buffer. Throughput: one character per cycle while
// two buffer slots are free; a character that yields two tokens queues both
// for the single token port, absorbed by the 4-entry buffer.
// Reset (arst_n low, asynchronous) empties the queue and token buffer and puts
// the scanner between tokens at text position 0; no clearing pass is needed.
module script_token_scanner_top import sts_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sts_text_if.sink    text,
	sts_token_if.source tokens
);

	// Front: classifies each character (class flags, NUL folded into end of text).
	logic push_valid;
	logic push_ready;
	cls_t push_item;

	// Queue: two classified items, so the front can take up to two characters
	// while the scanner waits on a full token buffer.
	logic pop_valid;
	logic pop_ready;
	cls_t pop_item;

	sts_front u_front (
		.text       (text),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	sts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// Back: scanner state machine plus token buffer. It takes a character
	// whenever two buffer slots are free, emitting a flushed lexeme and/or a
	// symbol or EOF token for it.
	sts_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_item  (pop_item),
		.q_ready (pop_ready),
		.tokens  (tokens)
	);

endmodule

/* sim/sts_token_checker.sv */
`timescale 1ns / 1ps

module sts_token_checker import sts_pkg::*; #(
	parameter int POS_BITS = POSITION_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	sts_text_if   text,
	sts_token_if  tokens,
	output int    failures,
	output int    outstanding
);

	localparam int PRINT_LIMIT = 200;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_OPER
	} scan_state_t;

	scan_state_t mode;
	logic [7:0]  op_char;
	pos_t        lex_start;
	pos_t        lex_count;
	pos_t        text_pos;
	logic [39:0] kw_word;   // first five ident chars, first char highest
	logic [7:0]  lead;

	tok_t step_tokens[$];
	tok_t due_tokens[$];

	function automatic pos_t bump(input pos_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic op_lead(input logic [7:0] c);
		return c == "=" || c == "!" || c == "<" || c == ">" || c == "+" || c == "-";
	endfunction

	function automatic logic [4:0] ident_kind();
		if (lex_count > pos_t'(5))
			return KIND_IDENT;
		case (kw_word)
			"func":  return KIND_FUNC;
			"print": return KIND_PRINT;
			"int":   return KIND_INT;
			"list":  return KIND_LIST;
			"array": return KIND_ARRAY;
			"if":    return KIND_IF;
			"elif":  return KIND_ELIF;
			"else":  return KIND_ELSE;
			"for":   return KIND_FOR;
			"while": return KIND_WHILE;
			default: return KIND_IDENT;
		endcase
	endfunction

	// Two-char operator formed by a pending lead and the next char;
	// KIND_SYMBOL means no pair (a pair is never a symbol).
	function automatic logic [4:0] operator_pair(input logic [7:0] first, input logic [7:0] c);
		if (c == "=") begin
			case (first)
				"=":     return KIND_EQ;
				"!":     return KIND_NEQ;
				"<":     return KIND_LTE;
				">":     return KIND_GTE;
				default: return KIND_SYMBOL;
			endcase
		end
		if (c == first && c == "+")
			return KIND_INC;
		if (c == first && c == "-")
			return KIND_DEC;
		return KIND_SYMBOL;
	endfunction

	function automatic void emit(input logic [4:0] kind, input pos_t start, input pos_t len,
		input logic [7:0] first);
		tok_t t;
		t.kind   = kind;
		t.start  = TOK_POS_W'(start);
		t.length = TOK_POS_W'(len);
		t.first  = first;
		t.last   = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic void clear_scanner();
		mode      = SCAN_IDLE;
		op_char   = '0;
		lex_start = '0;
		lex_count = '0;
		kw_word   = '0;
		text_pos  = '0;
		lead      = '0;
	endfunction

	function automatic void close_lexeme();
		case (mode)
			SCAN_IDENT:  emit(ident_kind(), lex_start, lex_count, lead);
			SCAN_NUMBER: emit(KIND_NUMBER, lex_start, lex_count, lead);
			SCAN_STRING: emit(KIND_STRING, lex_start, lex_count, lead);
			SCAN_OPER: begin
				if (op_char == "<")
					emit(KIND_LT, lex_start, pos_t'(1), op_char);
				else if (op_char == ">")
					emit(KIND_GT, lex_start, pos_t'(1), op_char);
				else
					emit(KIND_SYMBOL, lex_start, pos_t'(1), op_char);
			end
			default: ;
		endcase
		mode = SCAN_IDLE;
	endfunction

	function automatic void open_lexeme(input logic [7:0] c, input pos_t p);
		mode = SCAN_IDLE;
		if (blank(c)) begin
		end else if (letter(c) || c == "_") begin
			mode      = SCAN_IDENT;
			lex_start = p;
			lex_count = pos_t'(1);
			kw_word   = {32'd0, c};
			lead      = c;
		end else if (digit(c)) begin
			mode      = SCAN_NUMBER;
			lex_start = p;
			lex_count = pos_t'(1);
			lead      = c;
		end else if (c == "\"") begin
			// string body starts after the quote
			mode      = SCAN_STRING;
			lex_start = bump(p);
			lex_count = '0;
			lead      = '0;
		end else if (op_lead(c)) begin
			mode      = SCAN_OPER;
			op_char   = c;
			lex_start = p;
		end else begin
			emit(KIND_SYMBOL, p, pos_t'(1), c);
		end
	endfunction

	// Tokens caused by one accepted character, queued in order.
	function automatic void scan_character(input logic [7:0] c, input logic eot);
		pos_t       p;
		logic [4:0] pair;
		tok_t       t;
		p = text_pos;
		step_tokens.delete();
		if (eot || c == 8'd0) begin
			close_lexeme();
			emit(KIND_EOF, p, '0, 8'd0);
			clear_scanner();
		end else begin
			case (mode)
				SCAN_IDENT: begin
					if (letter(c) || digit(c) || c == "_") begin
						if (lex_count < pos_t'(5))
							kw_word = {kw_word[31:0], c};
						lex_count = bump(lex_count);
					end else begin
						close_lexeme();
						open_lexeme(c, p);
					end
				end
				SCAN_NUMBER: begin
					if (digit(c)) begin
						lex_count = bump(lex_count);
					end else begin
						close_lexeme();
						open_lexeme(c, p);
					end
				end
				SCAN_STRING: begin
					if (c == "\"") begin
						close_lexeme();
					end else begin
						if (lex_count == '0)
							lead = c;
						lex_count = bump(lex_count);
					end
				end
				SCAN_OPER: begin
					pair = operator_pair(op_char, c);
					if (pair != KIND_SYMBOL) begin
						emit(pair, lex_start, pos_t'(2), op_char);
						mode = SCAN_IDLE;
					end else begin
						close_lexeme();
						open_lexeme(c, p);
					end
				end
				default: open_lexeme(c, p);
			endcase
			text_pos = bump(p);
		end
		foreach (step_tokens[i]) begin
			t = step_tokens[i];
			t.last = (i == step_tokens.size() - 1);
			due_tokens.push_back(t);
		end
	endfunction

	task automatic report(input string msg);
		failures++;
		if (failures <= PRINT_LIMIT)
			$display("%t token mismatch: %s", $realtime, msg);
	endtask

	task automatic check_token();
		tok_t want;
		if (due_tokens.size() == 0) begin
			report($sformatf("unexpected token kind %0d start %0d length %0d",
				tokens.token_kind, tokens.token_start, tokens.token_length));
		end else begin
			want = due_tokens.pop_front();
			if (tokens.token_kind !== want.kind || tokens.token_start !== want.start ||
				tokens.token_length !== want.length || tokens.first_char !== want.first ||
				tokens.last_of_run !== want.last)
				report($sformatf({"kind %0d/%0d start %0d/%0d length %0d/%0d ",
					"first %0h/%0h last %0b/%0b (got/exp)"},
					tokens.token_kind, want.kind, tokens.token_start, want.start,
					tokens.token_length, want.length, tokens.first_char, want.first,
					tokens.last_of_run, want.last));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_scanner();
			due_tokens.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			// tokens lag their character (queue, then token buffer), so check before predicting
			if (tokens.valid && tokens.ready)
				check_token();
			if (text.valid && text.ready)
				scan_character(text.character, text.end_of_text);
			outstanding = due_tokens.size();
		end
	end

endmodule

/* sim/script_token_scanner_top_tb.sv */
`timescale 1ns / 1ps

module script_token_scanner_top_tb;

	localparam int RESET_CYCLES    = 10;
	localparam int RANDOM_ITEMS    = 650;
	localparam int HOLD_OFF_CYCLES = 64;
	// Worst honest quiet stretch is a long hold-off plus one long stall; this
	// is many times that.
	localparam int STALL_LIMIT     = 1000;
	localparam int DRAIN_CYCLES    = 8;
	localparam string IDENT_CHARS  =
		"_ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
	localparam string OP_LEADS     = "=!<>+-";

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sts_text_if  text();
	sts_token_if tokens();

	int failures;
	int outstanding;

	// Shared pacing controls: calm turns off idling on both sides,
	// hold_requests asks the receiver for one long hold-off.
	bit calm;
	int hold_requests;
	int holds_served;

	// Pending text, one entry per item: {end_of_text, character}.
	logic [8:0] text_buf[$];
	int random_items;
	int idle_cycles;

	string keywords[10] = '{"func", "print", "int", "list", "array",
		"if", "elif", "else", "for", "while"};
	string op_pairs[6] = '{"==", "!=", "<=", ">=", "++", "--"};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	script_token_scanner_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.tokens (tokens)
	);

	sts_token_checker token_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.text        (text),
		.tokens      (tokens),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Idle gap before an item: mostly none, some short, a few long.
	function automatic int sender_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Any byte the scanner treats as a lone symbol (includes 128..255).
	function automatic logic [7:0] symbol_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b inside {[8'd9:8'd13], " ", "_", "\"", "=", "!", "<", ">", "+", "-",
			["0":"9"], ["A":"Z"], ["a":"z"]});
		return b;
	endfunction

	// String body byte: anything but the closing quote and NUL.
	function automatic logic [7:0] content_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == "\"");
		return b;
	endfunction

	function automatic void put_item(input logic [7:0] c, input logic eot);
		text_buf.push_back({eot, c});
	endfunction

	function automatic void put_word(input string s);
		for (int i = 0; i < s.len(); i++)
			put_item(s[i], 1'b0);
	endfunction

	// Text terminator in one of its three forms; with end_of_text set the
	// character is a don't-care, so one of those forms sets it at random.
	function automatic void put_end();
		case ($urandom_range(0, 2))
			0:       put_item(8'd0, 1'b0);
			1:       put_item(8'($urandom_range(0, 255)), 1'b1);
			default: put_item(8'd0, 1'b1);
		endcase
	endfunction

	// Mostly well-formed tokens with random content, with near-miss keywords,
	// stray bytes and the odd unterminated string mixed in.
	function automatic void build_random_text();
		int    n_tok;
		string kw;
		n_tok = $urandom_range(0, 14);
		for (int t = 0; t < n_tok; t++) begin
			case ($urandom_range(0, 9))
				0: put_word(keywords[$urandom_range(0, 9)]);
				1: begin
					kw = keywords[$urandom_range(0, 9)];
					case ($urandom_range(0, 2))
						0: put_word(kw.substr(0, kw.len() - 2));
						1: begin
							put_word(kw);
							put_item(IDENT_CHARS[$urandom_range(0, 62)], 1'b0);
						end
						default: begin
							put_item(kw[0] - 8'd32, 1'b0);
							put_word(kw.substr(1, kw.len() - 1));
						end
					endcase
				end
				2: begin
					put_item(IDENT_CHARS[$urandom_range(0, 52)], 1'b0);
					repeat ($urandom_range(0, 7))
						put_item(IDENT_CHARS[$urandom_range(0, 62)], 1'b0);
				end
				3: repeat ($urandom_range(1, 6))
					put_item(8'($urandom_range(48, 57)), 1'b0);
				4: begin
					put_item("\"", 1'b0);
					repeat ($urandom_range(0, 6))
						put_item(content_byte(), 1'b0);
					// now and then leave it open; end of text closes it
					if ($urandom_range(0, 7) != 0)
						put_item("\"", 1'b0);
				end
				5: put_word(op_pairs[$urandom_range(0, 5)]);
				6: put_item(OP_LEADS[$urandom_range(0, 5)], 1'b0);
				7: put_item(symbol_byte(), 1'b0);
				8: put_item(8'($urandom_range(1, 255)), 1'b0);
				default: ;
			endcase
			case ($urandom_range(0, 3))
				0: ;
				1: put_item(" ", 1'b0);
				default: repeat ($urandom_range(1, 3))
					put_item(($urandom_range(0, 5) == 5) ? 8'd32
						: 8'($urandom_range(9, 13)), 1'b0);
			endcase
		end
		put_end();
	endfunction

	// Offer one item from the falling edge on, hold it until taken.
	task automatic send_char(input logic [8:0] item);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			text.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text.valid       <= 1'b1;
		text.character   <= item[7:0];
		text.end_of_text <= item[8];
		do
			@(posedge clk);
		while (!text.ready);
	endtask

	task automatic send_queued();
		foreach (text_buf[i])
			send_char(text_buf[i]);
		text_buf.delete();
	endtask

	// Receiver: ready changes only at the falling edge, one update per edge.
	initial begin
		int stall_left;
		int r;
		stall_left   = 0;
		holds_served = 0;
		tokens.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left   = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				tokens.ready <= 1'b0;
				stall_left--;
			end else if (calm) begin
				tokens.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					tokens.ready <= 1'b1;
				end else begin
					tokens.ready <= 1'b0;
					stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 30);
				end
			end
		end
	end

	// Watchdog: too long without any item moving on either channel.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if ((text.valid && text.ready) || (tokens.valid && tokens.ready))
					idle_cycles = 0;
				else
					idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		text.valid       = 1'b0;
		text.character   = 8'd0;
		text.end_of_text = 1'b0;
		calm             = 1'b0;
		hold_requests    = 0;
		random_items     = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Keyword cut short by >=, a number, an empty string, lone + and -,
		// a lone < ended by a high byte (two tokens from one item), then a
		// string with a high byte left open until NUL ends the text.
		put_word("if>=9 \"\"+-<");
		put_item(8'h80, 1'b0);
		put_item("\"", 1'b0);
		put_item(8'hFF, 1'b0);
		put_item(8'h00, 1'b0);
		send_queued();

		// Lone ! before an ident, !=, a lone >, ++, --, and a pending =
		// flushed by end_of_text with an all-ones character.
		put_word("!a!=b>_++--=");
		put_item(8'hFF, 1'b1);
		send_queued();

		for (int n = 0; random_items < RANDOM_ITEMS; n++) begin
			if (n == 2) begin
				// Back-pressure: a burst of symbols, a token per item, while
				// the receiver holds off, so the buffer fills and input stalls.
				calm = 1'b1;
				hold_requests++;
				repeat (40)
					put_item(symbol_byte(), 1'b0);
				put_end();
			end else begin
				calm = ($urandom_range(0, 3) == 0);
				build_random_text();
			end
			random_items += text_buf.size();
			send_queued();
		end

		@(negedge clk);
		text.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		// Let any stray token surface before the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
